FILE: design/sdtc_pkg.sv
// shared types and constants of the serial drum transfer controller
// used by every module in this folder; no dependencies
package sdtc_pkg;

  // device codes of the instruction item
  localparam logic [1:0] DEV_MA   = 2'd0;  // device 60: memory address and direction
  localparam logic [1:0] DEV_SEC  = 2'd1;  // device 61: done skip, clear, load sector
  localparam logic [1:0] DEV_CONT = 2'd2;  // device 62: error skip, continue

  // item kinds
  localparam logic OP_IOT  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // pulse bits
  localparam logic [5:0] PULSE_LDMA_MASK  = 6'o27;
  localparam logic [5:0] PULSE_LDMA_MATCH = 6'o06;
  localparam logic [5:0] PULSE_DIR        = 6'o40;
  localparam logic [5:0] PULSE_SKIP       = 6'o01;
  localparam logic [5:0] PULSE_CLEAR      = 6'o02;
  localparam logic [5:0] PULSE_START      = 6'o04;

  // configuration register indexes
  localparam logic CFG_IDX_LOCK  = 1'b0;
  localparam logic CFG_IDX_LIMIT = 1'b1;

  localparam int unsigned CFG_W       = 32;
  localparam int unsigned LIMIT_W     = 17;
  localparam int unsigned ACC_W       = 18;
  localparam int unsigned DADDR_W     = 17;
  localparam int unsigned MADDR_W     = 16;
  localparam int unsigned LOCK_GROUPS = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  // transfer phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_XFER = 3'b100
  } phase_t;

  // one input item
  typedef struct packed {
    logic             op;
    logic [1:0]       iot_device;
    logic [5:0]       pulse;
    logic [ACC_W-1:0] acc;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic               skip;
    logic               xfer_valid;
    logic               xfer_to_drum;
    logic [DADDR_W-1:0] drum_word_addr;
    logic [MADDR_W-1:0] mem_word_addr;
    logic               done_flag;
    logic               error_flag;
    logic               busy_res;
  } result_t;

endpackage

FILE: design/sdtc_in_stage.sv
// input register of the drum controller: holds one accepted item
// depends on sdtc_pkg for the item type
module sdtc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sdtc_pkg::in_item_t in_item,
  input  logic              adv,
  output logic              s1_valid,
  output sdtc_pkg::in_item_t s1_item
);

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  sdtc_pkg::in_item_t s1_item_r;
  logic               take;
  logic               load;

  // item leaves when the result side can take it
  assign take     = s1_valid_r & adv;
  assign in_stall = s1_valid_r & ~adv;
  assign load     = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

FILE: design/sdtc_ctrl.sv
// controller state and per-item work: instruction decode, rotation, transfer
// depends on sdtc_pkg for item, result and phase types
module sdtc_ctrl #(
  parameter int unsigned WORDS_PER_SECTOR  = 256,
  parameter int unsigned SECTORS_PER_TRACK = 2,
  parameter int unsigned TRACK_COUNT       = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [sdtc_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            fire,
  input  sdtc_pkg::in_item_t              item,
  output sdtc_pkg::result_t               res
);

  localparam int unsigned WORDS_PER_TRACK = WORDS_PER_SECTOR * SECTORS_PER_TRACK;
  localparam int unsigned SECTOR_COUNT    = TRACK_COUNT * SECTORS_PER_TRACK;
  localparam int unsigned SEC_W = $clog2(SECTOR_COUNT);
  localparam int unsigned POS_W = $clog2(WORDS_PER_TRACK);
  localparam int unsigned WC_W  = $clog2(WORDS_PER_SECTOR);
  localparam int unsigned SUB_W = (SECTORS_PER_TRACK > 1) ? $clog2(SECTORS_PER_TRACK) : 1;
  localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTOR_COUNT - 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WORDS_PER_TRACK - 1);
  localparam logic [WC_W-1:0]  WC_LAST  = WC_W'(WORDS_PER_SECTOR - 1);
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(SECTORS_PER_TRACK - 1);

  // accumulator reduced by a constant modulus: a mask when it is a power of
  // two, otherwise a short chain of conditional subtracts of shifted multiples
  function automatic logic [sdtc_pkg::ACC_W-1:0] acc_mod(
    input logic [sdtc_pkg::ACC_W-1:0] v,
    input int unsigned                m
  );
    logic [2*sdtc_pkg::ACC_W-1:0] r;
    logic [2*sdtc_pkg::ACC_W-1:0] d;
    r = {{sdtc_pkg::ACC_W{1'b0}}, v};
    if ((m & (m - 1)) == 0) begin
      r = r & ((2*sdtc_pkg::ACC_W)'(m) - 1'b1);
    end else begin
      for (int k = sdtc_pkg::ACC_W - 1; k >= 0; k--) begin
        d = (2*sdtc_pkg::ACC_W)'(m) << k;
        if (r >= d) begin
          r = r - d;
        end
      end
    end
    return r[sdtc_pkg::ACC_W-1:0];
  endfunction

  // configuration registers
  logic [sdtc_pkg::CFG_W-1:0]   lock_mask_r;
  logic [sdtc_pkg::LIMIT_W-1:0] mem_limit_r;

  // controller state
  logic [SEC_W-1:0]             sector_r,  sector_nxt;
  logic [SUB_W-1:0]             sub_r,     sub_nxt;
  logic [sdtc_pkg::MADDR_W-1:0] maddr_r,   maddr_nxt;
  logic                         err_r,     err_nxt;
  logic                         done_r,    done_nxt;
  logic                         dir_r,     dir_nxt;
  logic [POS_W-1:0]             pos_r,     pos_nxt;
  sdtc_pkg::phase_t             phase_r,   phase_nxt;
  logic [WC_W-1:0]              wc_r,      wc_nxt;

  logic                         busy;
  logic [POS_W-1:0]             target;
  logic [WC_W-1:0]              wc_use;
  logic [31:0]                  daddr_full;
  logic [31:0]                  lock_grp;
  logic                         locked;
  logic                         in_xfer;
  logic [sdtc_pkg::ACC_W-1:0]   sec_ld;
  logic [sdtc_pkg::ACC_W-1:0]   sub_ld;

  assign busy   = (phase_r != sdtc_pkg::PH_IDLE);
  assign target = POS_W'(32'(sub_r) * WORDS_PER_SECTOR);
  assign sec_ld = acc_mod(item.acc, SECTOR_COUNT);
  assign sub_ld = acc_mod(item.acc, SECTORS_PER_TRACK);

  // drum address and lock lookup for the word that may move now
  assign daddr_full = 32'(sector_r) * WORDS_PER_SECTOR + 32'(wc_use);
  assign lock_grp   = 32'(sector_r) >> 4;
  assign locked     = (lock_grp < sdtc_pkg::LOCK_GROUPS) && lock_mask_r[lock_grp[4:0]];

  // next state and result of the item in hand
  always_comb begin
    sector_nxt = sector_r;
    sub_nxt    = sub_r;
    maddr_nxt  = maddr_r;
    err_nxt    = err_r;
    done_nxt   = done_r;
    dir_nxt    = dir_r;
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    wc_nxt     = wc_r;
    wc_use     = wc_r;
    in_xfer    = 1'b0;
    res        = '0;

    if (item.op == sdtc_pkg::OP_IOT) begin
      case (item.iot_device)
        sdtc_pkg::DEV_MA: begin
          if ((item.pulse & sdtc_pkg::PULSE_LDMA_MASK) == sdtc_pkg::PULSE_LDMA_MATCH) begin
            maddr_nxt = item.acc[sdtc_pkg::MADDR_W-1:0];
            dir_nxt   = |(item.pulse & sdtc_pkg::PULSE_DIR);
          end
        end
        sdtc_pkg::DEV_SEC: begin
          res.skip = (|(item.pulse & sdtc_pkg::PULSE_SKIP)) & done_r;
          if (|(item.pulse & sdtc_pkg::PULSE_CLEAR)) begin
            done_nxt = 1'b0;
            err_nxt  = 1'b0;
          end
          if ((|(item.pulse & sdtc_pkg::PULSE_START)) && !busy) begin
            sector_nxt = sec_ld[SEC_W-1:0];
            sub_nxt    = sub_ld[SUB_W-1:0];
            phase_nxt  = sdtc_pkg::PH_WAIT;
            wc_nxt     = '0;
          end
        end
        sdtc_pkg::DEV_CONT: begin
          res.skip = (|(item.pulse & sdtc_pkg::PULSE_SKIP)) & ~err_r;
          if (|(item.pulse & sdtc_pkg::PULSE_START)) begin
            done_nxt = 1'b0;
            err_nxt  = 1'b0;
            if (!busy) begin
              phase_nxt = sdtc_pkg::PH_WAIT;
              wc_nxt    = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end else begin
      // word-time tick: advance rotation, start or continue a sector
      pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
      if (phase_r == sdtc_pkg::PH_WAIT && pos_nxt == target) begin
        in_xfer = 1'b1;
        wc_use  = '0;
      end else if (phase_r == sdtc_pkg::PH_XFER) begin
        in_xfer = 1'b1;
      end
      if (in_xfer) begin
        if (dir_r) begin
          if (locked) begin
            err_nxt = 1'b1;
          end else begin
            res.xfer_valid = 1'b1;
          end
        end else if ({1'b0, maddr_r} < mem_limit_r) begin
          res.xfer_valid = 1'b1;
        end
        if (res.xfer_valid) begin
          res.xfer_to_drum   = dir_r;
          res.drum_word_addr = daddr_full[sdtc_pkg::DADDR_W-1:0];
          res.mem_word_addr  = maddr_r;
        end
        maddr_nxt = maddr_r + 1'b1;
        if (wc_use == WC_LAST) begin
          sector_nxt = (sector_r == SEC_LAST) ? '0 : sector_r + 1'b1;
          sub_nxt    = (sub_r == SUB_LAST) ? '0 : sub_r + 1'b1;
          done_nxt   = 1'b1;
          phase_nxt  = sdtc_pkg::PH_IDLE;
          wc_nxt     = '0;
        end else begin
          phase_nxt = sdtc_pkg::PH_XFER;
          wc_nxt    = wc_use + 1'b1;
        end
      end
    end

    res.done_flag  = done_nxt;
    res.error_flag = err_nxt;
    res.busy_res   = (phase_nxt != sdtc_pkg::PH_IDLE);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_mask_r <= '0;
      mem_limit_r <= sdtc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == sdtc_pkg::CFG_IDX_LOCK) begin
        lock_mask_r <= cfg_wdata;
      end else begin
        mem_limit_r <= cfg_wdata[sdtc_pkg::LIMIT_W-1:0];
      end
    end
  end

  // state update as the item passes to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_r <= '0;
      sub_r    <= '0;
      maddr_r  <= '0;
      err_r    <= 1'b0;
      done_r   <= 1'b0;
      dir_r    <= 1'b0;
      pos_r    <= '0;
      phase_r  <= sdtc_pkg::PH_IDLE;
      wc_r     <= '0;
    end else if (fire) begin
      sector_r <= sector_nxt;
      sub_r    <= sub_nxt;
      maddr_r  <= maddr_nxt;
      err_r    <= err_nxt;
      done_r   <= done_nxt;
      dir_r    <= dir_nxt;
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      wc_r     <= wc_nxt;
    end
  end

endmodule

FILE: design/sdtc_out_stage.sv
// result register of the drum controller with its valid flag
// depends on sdtc_pkg for the result type
module sdtc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sdtc_pkg::result_t res_in,
  input  logic              out_stall,
  output logic              adv,
  output logic              out_valid,
  output sdtc_pkg::result_t res_out
);

  logic              out_valid_r;
  logic              out_valid_nxt;
  sdtc_pkg::result_t res_r;

  // free when empty or when the held result is taken this cycle
  assign adv = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = out_valid_r;
  assign res_out   = res_r;

endmodule

FILE: design/serial_drum_transfer_controller_core.sv
// top level of the sector-addressed serial drum transfer controller
// depends on sdtc_pkg, sdtc_in_stage, sdtc_ctrl and sdtc_out_stage

// Takes one item per clock cycle unless the result side stalls, either an I/O
// instruction on devices 60..62 or one drum word-time tick, and returns exactly
// one result item for each. An accepted item is held in the input register,
// then the controller decodes it against its state and writes the result
// register; the state update and result register load happen in the same cycle,
// letting a new item enter every cycle. Ticks advance a rotation counter modulo
// one track; after a start the block waits for the sector's first word, then
// steps one word per tick through the sector, issuing a transfer command unless
// the write lock or memory limit refuses it, then bumps the sector and sets
// done. The user must write configuration (write lock mask, memory limit) only
// while no item is in flight; the block does not enforce it.
module serial_drum_transfer_controller_core #(
  parameter int unsigned WORDS_PER_SECTOR  = 256,
  parameter int unsigned SECTORS_PER_TRACK = 2,
  parameter int unsigned TRACK_COUNT       = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [1:0]  in_iot_device,
  input  logic [5:0]  in_pulse,
  input  logic [17:0] in_acc,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_skip,
  output logic        out_xfer_valid,
  output logic        out_xfer_to_drum,
  output logic [16:0] out_drum_word_addr,
  output logic [15:0] out_mem_word_addr,
  output logic        out_done_flag,
  output logic        out_error_flag,
  output logic        out_busy_res
);

  sdtc_pkg::in_item_t in_item;
  sdtc_pkg::in_item_t s1_item;
  sdtc_pkg::result_t  res_c;
  sdtc_pkg::result_t  res_q;
  logic               s1_valid;
  logic               adv;
  logic               fire;

  // pack the input item
  assign in_item.op         = in_op;
  assign in_item.iot_device = in_iot_device;
  assign in_item.pulse      = in_pulse;
  assign in_item.acc        = in_acc;

  assign fire = s1_valid & adv;

  sdtc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  sdtc_ctrl #(
    .WORDS_PER_SECTOR  (WORDS_PER_SECTOR),
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
    .TRACK_COUNT       (TRACK_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (s1_item),
    .res       (res_c)
  );

  sdtc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_in    (res_c),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  // unpack the result item
  assign out_skip           = res_q.skip;
  assign out_xfer_valid     = res_q.xfer_valid;
  assign out_xfer_to_drum   = res_q.xfer_to_drum;
  assign out_drum_word_addr = res_q.drum_word_addr;
  assign out_mem_word_addr  = res_q.mem_word_addr;
  assign out_done_flag      = res_q.done_flag;
  assign out_error_flag     = res_q.error_flag;
  assign out_busy_res       = res_q.busy_res;

`ifndef SYNTHESIS
  // transfer fields are zero when no word moves
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_xfer_valid |->
      out_drum_word_addr == '0 && out_mem_word_addr == '0 && !out_xfer_to_drum)
    else $error("transfer fields set without a transfer");

  // the input side only stalls while its register holds an item
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  // an item leaving the input register always shows up as a result
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("item processed but no result presented");

  // a skip is only ever requested by an instruction
  a_tick_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_item.op == sdtc_pkg::OP_TICK |=> !out_skip)
    else $error("skip raised on a tick");
`endif

endmodule
